FILE: rtl/mdr_pkg.sv
// Shared types and constants of the multiplicative digital root binner.
`timescale 1ns / 1ps
`default_nettype none

package mdr_pkg;

  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned BASE_W         = 5;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 5;
  localparam int unsigned BITS_PER_CYCLE = 8;
  localparam int unsigned DIV_CYCLES     = VALUE_W / BITS_PER_CYCLE;
  localparam int unsigned CNT_W          = $clog2(DIV_CYCLES);

  localparam logic [CFG_INDEX_W-1:0] REG_NEGATIVE_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_BASE    = 2'd1;

  localparam logic [MODE_W-1:0] MODE_MAGNITUDE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DROP      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REJECT    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_BINNED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

  localparam logic [BASE_W-1:0] BASE_MIN     = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX     = 5'd16;
  localparam logic [BASE_W-1:0] BASE_DEFAULT = 5'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_CHK,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic                load_item;
    logic                div_step;
    logic                mul_step;
    logic                new_round;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic neg;
    logic step_last;
    logic quot_zero;
    logic prod_lt_base;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/mdr_datapath.sv
// Datapath: digit division, digit product, round check and result register.
`timescale 1ns / 1ps
`default_nettype none

module mdr_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [mdr_pkg::VALUE_W-1:0]     value_i,
  input  wire logic [mdr_pkg::BASE_W-1:0]      cfg_base_i,
  input  wire mdr_pkg::dp_cmd_t                cmd_i,
  output mdr_pkg::dp_sts_t                     sts_o,
  output logic [mdr_pkg::DIGIT_W-1:0]          root_bin_o,
  output logic [mdr_pkg::STATUS_W-1:0]         status_o
);
  import mdr_pkg::*;

  logic [VALUE_W-1:0]  dvd_q, dvd_d;
  logic [VALUE_W-1:0]  prod_q, prod_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic [BASE_W-1:0]   base_q, base_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DIGIT_W-1:0]  root_q;
  logic [STATUS_W-1:0] status_q;

  logic [VALUE_W-1:0]  mag;
  logic [BASE_W-1:0]   base_clamped;
  logic [VALUE_W-1:0]  step_dvd;
  logic [DIGIT_W-1:0]  step_rem;
  logic [VALUE_W-1:0]  mul_res;

  assign mag = value_i[VALUE_W-1] ? (~value_i + VALUE_W'(1)) : value_i;

  always_comb begin
    if (cfg_base_i < BASE_MIN) begin
      base_clamped = BASE_MIN;
    end else if (cfg_base_i > BASE_MAX) begin
      base_clamped = BASE_MAX;
    end else begin
      base_clamped = cfg_base_i;
    end
  end

  // Restoring division by the base, several quotient bits per cycle.
  always_comb begin
    logic [VALUE_W-1:0] dvd_v;
    logic [DIGIT_W-1:0] rem_v;
    logic [BASE_W-1:0]  trial_v;
    dvd_v = dvd_q;
    rem_v = rem_q;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      trial_v = {rem_v, dvd_v[VALUE_W-1]};
      dvd_v   = {dvd_v[VALUE_W-2:0], 1'b0};
      if (trial_v >= base_q) begin
        trial_v  = trial_v - base_q;
        dvd_v[0] = 1'b1;
      end
      rem_v = trial_v[DIGIT_W-1:0];
    end
    step_dvd = dvd_v;
    step_rem = rem_v;
  end

  assign mul_res = prod_q * {{(VALUE_W-DIGIT_W){1'b0}}, rem_q};

  always_comb begin
    dvd_d  = dvd_q;
    prod_d = prod_q;
    rem_d  = rem_q;
    base_d = base_q;
    cnt_d  = cnt_q;
    if (cmd_i.load_item) begin
      dvd_d  = mag;
      prod_d = VALUE_W'(1);
      rem_d  = '0;
      base_d = base_clamped;
      cnt_d  = '0;
    end else if (cmd_i.div_step) begin
      dvd_d = step_dvd;
      rem_d = step_rem;
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.mul_step) begin
      prod_d = mul_res;
      rem_d  = '0;
      cnt_d  = '0;
    end else if (cmd_i.new_round) begin
      dvd_d  = prod_q;
      prod_d = VALUE_W'(1);
      rem_d  = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    base_q <= base_d;
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      root_q   <= (cmd_i.out_status == STATUS_BINNED) ? prod_q[DIGIT_W-1:0] : '0;
    end
  end

  assign sts_o.neg          = value_i[VALUE_W-1];
  assign sts_o.step_last    = (cnt_q == CNT_W'(DIV_CYCLES - 1));
  assign sts_o.quot_zero    = (dvd_q == '0);
  assign sts_o.prod_lt_base = (prod_q < {{(VALUE_W-BASE_W){1'b0}}, base_q});

  assign root_bin_o = root_q;
  assign status_o   = status_q;

endmodule

`default_nettype wire

FILE: rtl/mdr_ctrl.sv
// Controller: sequences digit rounds and owns the input and output handshakes.
`timescale 1ns / 1ps
`default_nettype none

module mdr_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  input  wire logic [mdr_pkg::MODE_W-1:0]  cfg_mode_i,
  input  wire mdr_pkg::dp_sts_t            sts_i,
  output mdr_pkg::dp_cmd_t                 cmd_o
);
  import mdr_pkg::*;

  ctrl_state_e         state_q, state_d;
  logic [STATUS_W-1:0] pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    pend_d         = pend_q;
    cmd_o          = '0;
    cmd_o.out_status = pend_q;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.neg && (cfg_mode_i != MODE_MAGNITUDE)) begin
            pend_d  = (cfg_mode_i == MODE_DROP) ? STATUS_DROPPED : STATUS_REJECTED;
            state_d = ST_FIN;
          end else begin
            pend_d          = STATUS_BINNED;
            cmd_o.load_item = 1'b1;
            state_d         = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d = sts_i.quot_zero ? ST_CHK : ST_DIV;
      end
      ST_CHK: begin
        if (sts_i.prod_lt_base) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.new_round = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= STATUS_BINNED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/multiplicative_digital_root_binner_unit.sv
// Top level of the multiplicative digital root binner: config registers and wiring.
`timescale 1ns / 1ps
`default_nettype none

// Each transfer on the input carries one signed 64-bit value; each transfer
// on the output carries its bin (the multiplicative digital root in the
// configured base, clamped to 2..16) and a status. One item is in work at a
// time. With the output register free, a negative value that is dropped or
// rejected passes from idle to the finish state, which then loads the output
// register and raises output valid. For a binned value the digit divider
// yields 8 quotient bits per cycle; each digit of the 64-bit word takes its
// divide steps and then one multiply step, and each round ends with one
// compare step. Later rounds work on much smaller products but still walk all
// 64 bits per digit. A finished result waits in the output register while
// the next input transfer is taken. Write configuration only while the block
// is idle.
module multiplicative_digital_root_binner_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [mdr_pkg::VALUE_W-1:0] value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [mdr_pkg::DIGIT_W-1:0]            root_bin_o,
  output logic [mdr_pkg::STATUS_W-1:0]           status_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [mdr_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [mdr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import mdr_pkg::*;

  logic [MODE_W-1:0] mode_q;
  logic [BASE_W-1:0] base_q;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  // Hold the two config registers; writes to unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_REJECT;
      base_q <= BASE_DEFAULT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_NEGATIVE_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        REG_DIGIT_BASE:    base_q <= cfg_data_i[BASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequence the divide, multiply and round-check steps.
  mdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_mode_i  (mode_q),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Magnitude, base clamp, digit divider, product and output register.
  mdr_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (value_i),
    .cfg_base_i (base_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .root_bin_o (root_bin_o),
    .status_o   (status_o)
  );

endmodule

`default_nettype wire

FILE: rtl/mdr_checker.sv
// Port-level checker for the binner and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mdr_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_ready_o,
  input  wire logic [mdr_pkg::VALUE_W-1:0]       value_i,
  input  wire logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  input  wire logic [mdr_pkg::DIGIT_W-1:0]       root_bin_o,
  input  wire logic [mdr_pkg::STATUS_W-1:0]      status_o
);
  import mdr_pkg::*;

  // A dropped or rejected item reports bin zero.
  a_root_zero_unbinned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STATUS_BINNED) |-> (root_bin_o == '0))
    else $error("nonzero bin on an unbinned result");

  // The unused status code never shows.
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_BINNED || status_o == STATUS_DROPPED ||
                     status_o == STATUS_REJECTED))
    else $error("illegal status code");

  // One item in work: the input closes right after a transfer.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // A waiting input item holds.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(value_i)))
    else $error("waiting input item changed");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(root_bin_o) && $stable(status_o)))
    else $error("stalled result changed");

endmodule

bind multiplicative_digital_root_binner_unit mdr_checker u_mdr_checker (.*);

`default_nettype wire
